FILE: rtl/core/prp_pkg.sv
package prp_pkg;

	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 16;

	// frame index and walk counter widths
	localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int WCNT_W  = $clog2(FRAMES + 1);

	localparam int STAMP_W = 32;
	localparam int UCNT_W  = 16;
	localparam int FAULT_W = 32;

	// fixed port widths
	localparam int PAGE_PORT_W = 16;
	localparam int FIDX_PORT_W = 2;
	localparam int MODE_W      = 2;

	// apb map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_POLICY = 1'b0;

	localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LFU  = 2'd2;

	localparam logic CMD_REF   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic [STAMP_W-1:0]   stamp;
		logic [UCNT_W-1:0]    ucnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic                   hit;
		logic [FIDX_PORT_W-1:0] frame_index;
		logic                   evict_valid;
		logic [PAGE_PORT_W-1:0] evicted_page;
		logic [FAULT_W-1:0]     fault_total;
	} res_t;

endpackage

FILE: rtl/core/prp_frame_ram.sv
module prp_frame_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/prp_apb_regs.sv
module prp_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [prp_pkg::PADDR_W-1:0]   paddr,
	input  logic [prp_pkg::PDATA_W-1:0]   pwdata,
	output logic [prp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [prp_pkg::MODE_W-1:0]    policy_mode
);

	logic [prp_pkg::MODE_W-1:0] mode_q;
	logic                       reg_idx;
	logic                       wr_fire;

	assign pready  = 1'b1;
	assign reg_idx = paddr[prp_pkg::PADDR_W-1];
	assign wr_fire = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= prp_pkg::MODE_FIFO;
		end else if (wr_fire && reg_idx == prp_pkg::REG_POLICY) begin
			mode_q <= pwdata[prp_pkg::MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == prp_pkg::REG_POLICY) begin
			prdata = {{(prp_pkg::PDATA_W - prp_pkg::MODE_W){1'b0}}, mode_q};
		end
	end

	assign policy_mode = mode_q;

endmodule

FILE: rtl/core/prp_ctrl.sv
module prp_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [prp_pkg::MODE_W-1:0]        policy_mode,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic [prp_pkg::PAGE_PORT_W-1:0]   page_number,
	output logic                              res_valid,
	input  logic                              res_ready,
	output prp_pkg::res_t                     res
);

	localparam int FR = prp_pkg::FRAMES;
	localparam int FW = prp_pkg::FIDX_W;
	localparam int CW = prp_pkg::WCNT_W;
	localparam int PB = prp_pkg::PAGE_BITS;

	prp_pkg::state_t state_q, state_d;

	logic [FR-1:0]               valid_q;
	logic [prp_pkg::STAMP_W-1:0] ref_cnt_q;
	logic [prp_pkg::FAULT_W-1:0] fault_cnt_q;
	logic [FW-1:0]               fifo_ptr_q;
	logic [CW-1:0]               rd_cnt_q;
	logic                        chk_vld_s1;
	logic [FW-1:0]               chk_idx_s1;

	logic [PB-1:0]               page_q;
	logic                        hit_q;
	logic [FW-1:0]               hit_idx_q;
	logic [prp_pkg::UCNT_W-1:0]  hit_cnt_q;
	logic [FW-1:0]               best_idx_q;
	logic [PB-1:0]               best_page_q;
	logic [prp_pkg::STAMP_W-1:0] best_stamp_q;
	logic [prp_pkg::UCNT_W-1:0]  best_cnt_q;

	logic                        in_take;
	logic                        rd_en;
	logic [FW-1:0]               rd_addr;
	logic [prp_pkg::ENTRY_W-1:0] rd_data;
	prp_pkg::entry_t             rd_ent;
	logic                        wr_en;
	prp_pkg::entry_t             wr_ent;
	logic                        walk_done;
	logic                        res_fire;

	logic [PB+prp_pkg::PAGE_PORT_W-1:0] page_ext;
	logic                        match;
	logic                        take_best;
	logic                        empty_any;
	logic [FW-1:0]               empty_idx;
	logic [FW-1:0]               slot;
	logic [FW+1:0]               slot_ext;
	logic                        evict;
	logic [PB+prp_pkg::PAGE_PORT_W-1:0] old_ext;
	logic [prp_pkg::FAULT_W-1:0] fault_nxt;

	assign in_take   = in_valid && !in_stall;
	assign page_ext  = {{PB{1'b0}}, page_number};
	assign rd_en     = (state_q == prp_pkg::ST_WALK) && (rd_cnt_q != CW'(FR));
	assign rd_addr   = rd_cnt_q[FW-1:0];
	assign rd_ent    = prp_pkg::entry_t'(rd_data);
	assign walk_done = chk_vld_s1 && (chk_idx_s1 == FW'(FR - 1));

	prp_frame_ram #(
		.WIDTH (prp_pkg::ENTRY_W),
		.DEPTH (FR)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot),
		.wdata (wr_ent),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			prp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && cmd == prp_pkg::CMD_REF) begin
					state_d = prp_pkg::ST_WALK;
				end
			end
			prp_pkg::ST_WALK: begin
				if (walk_done) begin
					state_d = prp_pkg::ST_WRITE;
				end
			end
			prp_pkg::ST_WRITE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = prp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prp_pkg::ST_IDLE;
			end
		endcase
	end

	assign res_fire = res_valid && res_ready;
	assign wr_en    = res_fire;

	// compare the entry read last cycle against the request
	always_comb begin
		match     = valid_q[chk_idx_s1] && (rd_ent.page == page_q);
		take_best = 1'b0;
		if (chk_idx_s1 == '0) begin
			take_best = 1'b1;
		end else begin
			unique case (policy_mode)
				prp_pkg::MODE_LRU: take_best = rd_ent.stamp < best_stamp_q;
				prp_pkg::MODE_LFU: take_best = rd_ent.ucnt < best_cnt_q;
				default:           take_best = chk_idx_s1 == fifo_ptr_q;
			endcase
		end
	end

	// lowest empty frame
	always_comb begin
		empty_any = 1'b0;
		empty_idx = '0;
		for (int i = FR - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				empty_any = 1'b1;
				empty_idx = FW'(i);
			end
		end
	end

	always_comb begin
		evict = !hit_q && !empty_any;
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (empty_any) begin
			slot = empty_idx;
		end else begin
			slot = best_idx_q;
		end
		slot_ext     = {2'b00, slot};
		old_ext      = {{prp_pkg::PAGE_PORT_W{1'b0}}, best_page_q};
		wr_ent.page  = page_q;
		wr_ent.stamp = ref_cnt_q;
		if (hit_q) begin
			wr_ent.ucnt = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + 1'b1;
		end else begin
			wr_ent.ucnt = prp_pkg::UCNT_W'(1);
		end
		if (hit_q || (&fault_cnt_q)) begin
			fault_nxt = fault_cnt_q;
		end else begin
			fault_nxt = fault_cnt_q + 1'b1;
		end
		res.hit          = hit_q;
		res.frame_index  = slot_ext[prp_pkg::FIDX_PORT_W-1:0];
		res.evict_valid  = evict;
		res.evicted_page = evict ? old_ext[prp_pkg::PAGE_PORT_W-1:0] : '0;
		res.fault_total  = fault_nxt;
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ref_cnt_q   <= '0;
			fault_cnt_q <= '0;
			fifo_ptr_q  <= '0;
			rd_cnt_q    <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			chk_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (in_take) begin
				rd_cnt_q <= '0;
				hit_q    <= 1'b0;
				if (cmd == prp_pkg::CMD_CLEAR) begin
					valid_q     <= '0;
					ref_cnt_q   <= '0;
					fault_cnt_q <= '0;
					fifo_ptr_q  <= '0;
				end else if (!(&ref_cnt_q)) begin
					ref_cnt_q <= ref_cnt_q + 1'b1;
				end
			end
			if (chk_vld_s1 && match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (res_fire) begin
				valid_q[slot] <= 1'b1;
				fault_cnt_q   <= fault_nxt;
				if (!hit_q) begin
					fifo_ptr_q <= (fifo_ptr_q == FW'(FR - 1)) ? '0 : fifo_ptr_q + 1'b1;
				end
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_addr;
		if (in_take) begin
			page_q <= page_ext[PB-1:0];
		end
		if (chk_vld_s1 && match && !hit_q) begin
			hit_idx_q <= chk_idx_s1;
			hit_cnt_q <= rd_ent.ucnt;
		end
		if (chk_vld_s1 && take_best) begin
			best_idx_q   <= chk_idx_s1;
			best_page_q  <= rd_ent.page;
			best_stamp_q <= rd_ent.stamp;
			best_cnt_q   <= rd_ent.ucnt;
		end
	end

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.evict_valid |-> (&valid_q))
		else $error("eviction while a frame is empty");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && cmd == prp_pkg::CMD_CLEAR |=> fault_cnt_q == '0 && valid_q == '0)
		else $error("clear did not empty the store");

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res.hit |=> fault_cnt_q == $past(fault_cnt_q))
		else $error("fault counted on a hit");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> state_q == prp_pkg::ST_WRITE)
		else $error("walk did not reach write");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> state_q == prp_pkg::ST_IDLE && !chk_vld_s1)
		else $error("sequencer busy after result");

endmodule

FILE: rtl/core/page_replacement_policy_core.sv
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   cmd, page_number
// out       out  out_valid / out_stall hit, frame_index, evict_valid, evicted_page, fault_total
// cfg       in   apb, pready tied high policy_mode at byte address 0
//
// a reference runs from one accepted transaction to the next through these steps: the
// accepting cycle, one read of the frame memory per frame through its single read port,
// the compare of the last read data, and the write of the chosen frame back. the result
// enters the output register together with that write-back; no new transaction is taken
// before it. a clear is taken in the idle state, stays there and gives no result.
// reset empties the store through per-frame valid bits at once, no clearing pass.
// a result waits in the output register; the next transaction is taken meanwhile,
// and its write-back waits while that register is full and out_stall is high.
module page_replacement_policy_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [prp_pkg::PADDR_W-1:0]       paddr,
	input  logic [prp_pkg::PDATA_W-1:0]       pwdata,
	output logic [prp_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic [prp_pkg::PAGE_PORT_W-1:0]   page_number,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [prp_pkg::FIDX_PORT_W-1:0]   frame_index,
	output logic                              evict_valid,
	output logic [prp_pkg::PAGE_PORT_W-1:0]   evicted_page,
	output logic [prp_pkg::FAULT_W-1:0]       fault_total
);

	logic [prp_pkg::MODE_W-1:0] policy_mode;
	logic                       res_valid;
	logic                       res_ready;
	prp_pkg::res_t              res;
	logic                       out_valid_q;
	prp_pkg::res_t              out_q;

	prp_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.policy_mode (policy_mode)
	);

	prp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.policy_mode (policy_mode),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.page_number (page_number),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_q.hit;
	assign frame_index  = out_q.frame_index;
	assign evict_valid  = out_q.evict_valid;
	assign evicted_page = out_q.evicted_page;
	assign fault_total  = out_q.fault_total;

endmodule
